@@ rtl/vkm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vkm_pkg: shared types and constants of the voice keyword matcher.
// Holds the keyword table, the command codes and the beat that travels
// down the cell chain.
// ---------------------------------------------------------------------------
package vkm_pkg;

  localparam int NUM_PAT = 7;
  localparam int MAX_PAT = 9;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_COME  = 3'd2,
    CMD_HOME  = 3'd3,
    CMD_SLEEP = 3'd4,
    CMD_WAKE  = 3'd5
  } cmd_t;

  localparam logic [0:2][7:0] PREFIX_TEXT = "VC:";

  localparam logic [0:NUM_PAT-1][0:MAX_PAT-1][7:0] PAT_TEXT = {
    {"STOP",      40'h0},
    {"COMEHERE",   8'h0},
    {"COME_", "HERE"   },
    {"GOHOME",    24'h0},
    {"GO_HOME",   16'h0},
    {"SLEEP",     32'h0},
    {"WAKE",      40'h0}
  };

  localparam logic [0:NUM_PAT-1][3:0] PAT_LEN = {
    4'd4, 4'd8, 4'd9, 4'd6, 4'd7, 4'd5, 4'd4
  };

  localparam cmd_t PAT_CMD [NUM_PAT] = '{
    CMD_STOP, CMD_COME, CMD_COME, CMD_HOME, CMD_HOME, CMD_SLEEP, CMD_WAKE
  };

  localparam logic [31:0] COOLDOWN_RESET = 32'd1000;

  // One beat of the chain. When pre_c is set, the replayed bytes "V" and
  // "C" are applied before chr; kept says whether chr itself is matched.
  typedef struct packed {
    logic        vld;
    logic [7:0]  chr;
    logic        kept;
    logic        pre_c;
    logic        last;
    logic [31:0] now;
    cmd_t        cmd;
  } tok_t;

endpackage
`default_nettype wire

@@ rtl/voice_keyword_matcher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// voice_keyword_matcher: keyword spotting over a byte stream.
// Front stage, a chain of seven keyword cells and a cooldown stage.
// ---------------------------------------------------------------------------
// The block takes one byte every clock cycle while in_stall is low. Each
// byte passes through the front stage, then through each keyword cell in
// turn down a chain of seven, then the cooldown stage, which registers the
// command for the line. The input stalls only while a finished command
// waits at the output and the next line's result has reached the end of
// the chain. Lines of any length may follow each other without gaps.
module voice_keyword_matcher #(
  parameter int KEPT_LIMIT = 31
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_char_code,
  input  wire         in_last_char,
  input  wire  [31:0] in_now_ms,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_command,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_cooldown_ms
);
  import vkm_pkg::*;

  tok_t        chain [NUM_PAT+1];
  tok_t        tail;
  logic        adv;
  logic        accept;
  logic        result_in;
  logic        in_time;

  logic        out_valid_r;
  cmd_t        out_command_r, out_command_nxt;
  logic [31:0] cooldown_r;
  logic [31:0] last_accept_r;

  assign tail      = chain[NUM_PAT];
  assign adv       = !(tail.vld && tail.last && out_valid_r && out_stall);
  assign accept    = in_valid && adv;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign result_in = adv && tail.vld && tail.last;

  vkm_front #(
    .KEPT_LIMIT (KEPT_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .accept    (accept),
    .char_code (in_char_code),
    .last_char (in_last_char),
    .now_ms    (in_now_ms),
    .tok_o     (chain[0])
  );

  for (genvar k = 0; k < NUM_PAT; k++) begin : g_cell
    vkm_cell #(
      .IDX (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (chain[k]),
      .tok_o (chain[k+1])
    );
  end

  always_comb begin
    in_time         = (tail.now - last_accept_r) >= cooldown_r;
    out_command_nxt = (tail.cmd != CMD_NONE && in_time) ? tail.cmd : CMD_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      cooldown_r    <= COOLDOWN_RESET;
      last_accept_r <= 32'd0;
    end else begin
      if (cfg_valid) begin
        cooldown_r <= cfg_cooldown_ms;
      end
      if (result_in) begin
        out_valid_r <= 1'b1;
        if (out_command_nxt != CMD_NONE) begin
          last_accept_r <= tail.now;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_in) begin
      out_command_r <= out_command_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_command = out_command_r;

endmodule
`default_nettype wire

@@ rtl/vkm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vkm_front: prefix removal, case folding and byte filtering.
// Turns each accepted input beat into one beat for the cell chain.
// ---------------------------------------------------------------------------
module vkm_front #(
  parameter int KEPT_LIMIT = 31
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              adv,
  input  wire              accept,
  input  wire [7:0]        char_code,
  input  wire              last_char,
  input  wire [31:0]       now_ms,
  output vkm_pkg::tok_t    tok_o
);
  import vkm_pkg::*;

  localparam int CW = $clog2(KEPT_LIMIT + 1);

  logic [1:0]    raw_r, raw_nxt;
  logic          intact_r, intact_nxt;
  logic [CW-1:0] count_r, count_nxt;
  tok_t          tok_r, tok_nxt;

  logic [7:0]    folded;
  logic [1:0]    pre_cnt;
  logic          pre_c;
  logic          feed;
  logic          wspace;
  logic          kept;
  logic [CW-1:0] base;

  always_comb begin
    folded = char_code;
    if (char_code >= "a" && char_code <= "z") begin
      folded = char_code - 8'd32;
    end
    wspace = (folded == " ") || (folded == 8'h0D) || (folded == 8'h0A);

    raw_nxt    = raw_r;
    intact_nxt = intact_r;
    pre_cnt    = 2'd0;
    pre_c      = 1'b0;
    feed       = 1'b1;
    if (raw_r != 2'd3) begin
      raw_nxt = raw_r + 2'd1;
      if (intact_r && char_code == PREFIX_TEXT[raw_r]) begin
        feed = 1'b0;
        if (last_char) begin
          case (raw_r)
            2'd0: begin
              pre_cnt = 2'd1;
            end
            2'd1: begin
              pre_cnt = 2'd2;
              pre_c   = 1'b1;
            end
            default: begin
              pre_cnt = 2'd0;
            end
          endcase
        end
      end else begin
        intact_nxt = 1'b0;
        if (intact_r) begin
          case (raw_r)
            2'd1: begin
              pre_cnt = 2'd1;
            end
            2'd2: begin
              pre_cnt = 2'd2;
              pre_c   = 1'b1;
            end
            default: begin
              pre_cnt = 2'd0;
            end
          endcase
        end
      end
    end

    base      = count_r + CW'(pre_cnt);
    kept      = feed && !wspace && (base < CW'(KEPT_LIMIT));
    count_nxt = base + CW'(kept);

    if (last_char) begin
      raw_nxt    = 2'd0;
      intact_nxt = 1'b1;
      count_nxt  = '0;
    end

    tok_nxt.vld   = accept;
    tok_nxt.chr   = folded;
    tok_nxt.kept  = kept;
    tok_nxt.pre_c = pre_c;
    tok_nxt.last  = last_char;
    tok_nxt.now   = now_ms;
    tok_nxt.cmd   = CMD_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 2'd0;
      intact_r <= 1'b1;
      count_r  <= '0;
      tok_r    <= '0;
    end else begin
      if (accept) begin
        raw_r    <= raw_nxt;
        intact_r <= intact_nxt;
        count_r  <= count_nxt;
      end
      if (adv) begin
        tok_r <= tok_nxt;
      end
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

@@ rtl/vkm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vkm_cell: one keyword automaton of the chain.
// Tracks its keyword over the passing beats and, on the last beat of a
// line, writes its command into the beat if no earlier cell has.
// ---------------------------------------------------------------------------
module vkm_cell #(
  parameter int IDX = 0
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              adv,
  input  vkm_pkg::tok_t    tok_i,
  output vkm_pkg::tok_t    tok_o
);
  import vkm_pkg::*;

  logic [3:0] q_r, q_nxt;
  logic       found_r, found_nxt;
  tok_t       tok_r, tok_nxt;

  logic [3:0] q_base;
  logic [3:0] q_step;
  logic       hit;

  always_comb begin
    q_base = q_r;
    if (tok_i.pre_c) begin
      q_base = (PAT_TEXT[IDX][0] == "C") ? 4'd1 : 4'd0;
    end
    if (q_base >= PAT_LEN[IDX]) begin
      q_base = 4'd0;
    end

    q_step = q_base;
    hit    = 1'b0;
    if (tok_i.kept) begin
      if (PAT_TEXT[IDX][q_base] == tok_i.chr) begin
        q_step = q_base + 4'd1;
      end else begin
        q_step = (PAT_TEXT[IDX][0] == tok_i.chr) ? 4'd1 : 4'd0;
      end
      if (q_step == PAT_LEN[IDX]) begin
        hit    = 1'b1;
        q_step = 4'd0;
      end
    end

    q_nxt     = q_step;
    found_nxt = found_r | hit;

    tok_nxt = tok_i;
    if (tok_i.last && tok_i.cmd == CMD_NONE && found_nxt) begin
      tok_nxt.cmd = PAT_CMD[IDX];
    end
    if (tok_i.last) begin
      q_nxt     = 4'd0;
      found_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r     <= 4'd0;
      found_r <= 1'b0;
      tok_r   <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
      if (tok_i.vld) begin
        q_r     <= q_nxt;
        found_r <= found_nxt;
      end
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

@@ rtl/vkm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// vkm_checker: port-level checks of the voice keyword matcher.
// Watches the handshakes and the reported command over time.
// ---------------------------------------------------------------------------
module vkm_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_valid,
  input wire         in_stall,
  input wire  [7:0]  in_char_code,
  input wire         in_last_char,
  input wire  [31:0] in_now_ms,
  input wire         out_valid,
  input wire         out_stall,
  input wire  [2:0]  out_command,
  input wire         cfg_valid,
  input wire         cfg_ready,
  input wire  [31:0] cfg_cooldown_ms
);
  import vkm_pkg::*;

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_command <= CMD_WAKE)
    else $error("command code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_command))
    else $error("stalled result beat changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind voice_keyword_matcher vkm_checker u_vkm_checker (.*);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the voice keyword matcher.
// Command lines are fed one byte per beat and each line end is predicted
// in the bench: prefix stripping, case folding, keyword search and cooldown.
// Reported commands are compared in order. Both sides stall at random, and
// the cooldown register is rewritten between phases while the block is idle.
// ---------------------------------------------------------------------------
module tb_top;
  import vkm_pkg::*;

  localparam int unsigned KEEP_MAX = 31;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam bit [7:0] SEP_BYTES [3] = '{8'h20, 8'h0D, 8'h0A};

  class keyword_scoreboard;
    bit [31:0]   cooldown;
    bit [31:0]   last_accept;
    int unsigned win_pos;
    bit          prefix_ok;
    bit [7:0]    held [2];
    int unsigned kept;
    int unsigned progress [7];
    bit [6:0]    found;
    string       kw_text [7];
    cmd_t        kw_cmd [7];
    string       prefix_txt;
    cmd_t        pending_cmds [$];
    int unsigned mismatches;

    function new();
      kw_text = '{"STOP", "COMEHERE", string'({"COME_", "HERE"}), "GOHOME", "GO_HOME",
                  "SLEEP", "WAKE"};
      kw_cmd = '{CMD_STOP, CMD_COME, CMD_COME, CMD_HOME, CMD_HOME, CMD_SLEEP, CMD_WAKE};
      prefix_txt = "VC:";
      cooldown = 32'd1000;
      last_accept = 32'd0;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      int k;
      win_pos = 0;
      prefix_ok = 1'b1;
      held[0] = 8'h00;
      held[1] = 8'h00;
      kept = 0;
      for (k = 0; k < 7; k++) progress[k] = 0;
      found = '0;
    endfunction

    function void fold_and_match(bit [7:0] c_in);
      bit [7:0] c;
      bit [7:0] p;
      int unsigned q;
      int k;
      c = c_in;
      if (c >= "a" && c <= "z") c = c - 8'd32;
      if (c == 8'h20 || c == 8'h0D || c == 8'h0A) return;
      if (kept >= KEEP_MAX) return;
      kept++;
      for (k = 0; k < 7; k++) begin
        q = progress[k];
        if (q >= kw_text[k].len()) q = 0;
        p = kw_text[k][q];
        if (p == c) begin
          q++;
        end else begin
          p = kw_text[k][0];
          q = (p == c) ? 1 : 0;
        end
        if (q == kw_text[k].len()) begin
          found[k] = 1'b1;
          q = 0;
        end
        progress[k] = q;
      end
    endfunction

    function void take_byte(bit [7:0] c, bit is_last, bit [31:0] stamp);
      int unsigned j;
      bit [7:0] p;
      bit [31:0] elapsed;
      cmd_t pick;
      if (win_pos < 3) begin
        p = prefix_txt[win_pos];
        if (prefix_ok && c == p) begin
          if (win_pos < 2) held[win_pos] = c;
          if (is_last && win_pos < 2) begin
            for (j = 0; j <= win_pos; j++) fold_and_match(held[j]);
          end
        end else begin
          if (prefix_ok) begin
            for (j = 0; j < win_pos; j++) fold_and_match(held[j]);
          end
          prefix_ok = 1'b0;
          fold_and_match(c);
        end
        win_pos++;
      end else begin
        fold_and_match(c);
      end
      if (!is_last) return;
      pick = CMD_NONE;
      for (j = 7; j > 0; j--) begin
        if (found[j-1]) pick = kw_cmd[j-1];
      end
      if (pick != CMD_NONE) begin
        elapsed = stamp - last_accept;
        if (elapsed >= cooldown) last_accept = stamp;
        else pick = CMD_NONE;
      end
      pending_cmds.push_back(pick);
      clear_line();
    endfunction

    function void complain(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_command(logic [2:0] got);
      cmd_t want;
      if (pending_cmds.size() == 0) begin
        complain("unexpected command", CMD_NONE, got);
        return;
      end
      want = pending_cmds.pop_front();
      if (got !== want) complain("command mismatch", want, got);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_code;
  logic        in_last_char;
  logic [31:0] in_now_ms;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_command;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_cooldown_ms;

  keyword_scoreboard sb = new();
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  bit [31:0]   wall_ms = 32'd0;
  bit [7:0]    line_buf [$];
  string       word_bank [16] = '{"STOP", "COMEHERE", string'({"COME_", "HERE"}), "GOHOME",
                                  "GO_HOME", "SLEEP", "WAKE", "COME HERE", "STO", "COMEHER",
                                  "GO_HOM", "SLEE", "WAK", "SSTOP", "GOGOHOME",
                                  string'({"COMCOME_", "HERE"})};
  string       prefix_bank [10] = '{"VC:", "VC:", "VC:", "VC:", "V", "VC", "vc:", "VC;",
                                    "Vx", ""};

  voice_keyword_matcher #(.KEPT_LIMIT(KEEP_MAX)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_last_char   (in_last_char),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_command    (out_command),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_cooldown_ms(cfg_cooldown_ms)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_command(out_command);
  end

  // The receiver stalls at random; on request it holds off for a long run.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 9);
    end
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void push_word(string s);
    int unsigned i;
    bit [7:0] c;
    for (i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "A" && c <= "Z" && $urandom_range(0, 3) == 0) c = c + 8'd32;
      line_buf.push_back(c);
      if ($urandom_range(0, 15) == 0) line_buf.push_back(SEP_BYTES[$urandom_range(0, 2)]);
    end
  endfunction

  function automatic void make_line(int unsigned max_frag);
    int unsigned n;
    int unsigned i;
    string s;
    line_buf.delete();
    s = prefix_bank[$urandom_range(0, 9)];
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(6, 10) : $urandom_range(0, max_frag);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0, 1, 2: push_word(word_bank[$urandom_range(0, 15)]);
        3: line_buf.push_back(8'd97 + 8'($urandom_range(0, 25)));
        4: line_buf.push_back(8'($urandom_range(1, 255)));
        default: line_buf.push_back(SEP_BYTES[$urandom_range(0, 2)]);
      endcase
    end
    if (line_buf.size() == 0) line_buf.push_back(8'd65 + 8'($urandom_range(0, 25)));
  endfunction

  function automatic bit [31:0] pick_now();
    wall_ms += $urandom_range(0, 2500);
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return wall_ms;
      default: return sb.last_accept + sb.cooldown + $urandom_range(0, 6) - 32'd3;
    endcase
  endfunction

  task automatic send_byte(input bit [7:0] c, input bit is_last, input bit [31:0] stamp);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 99) < 3) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_last_char <= is_last;
    in_now_ms <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(c, is_last, stamp);
  endtask

  task automatic send_line(input bit [31:0] stamp);
    int unsigned i;
    for (i = 0; i < line_buf.size(); i++) begin
      if (i == line_buf.size() - 1) send_byte(line_buf[i], 1'b1, stamp);
      else send_byte(line_buf[i], 1'b0, $urandom());
    end
  endtask

  task automatic send_text(input string s, input bit [31:0] stamp);
    int unsigned i;
    line_buf.delete();
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line(stamp);
  endtask

  task automatic random_lines(input int unsigned n_bytes, input int unsigned max_frag);
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      make_line(max_frag);
      sent += line_buf.size();
      send_line(pick_now());
    end
  endtask

  task automatic drain();
    int unsigned n;
    in_valid <= 1'b0;
    n = 0;
    while (sb.pending_cmds.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic write_cooldown(input bit [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_cooldown_ms <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.cooldown = value;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char_code <= 8'h00;
    in_last_char <= 1'b0;
    in_now_ms <= 32'd0;
    cfg_valid <= 1'b0;
    cfg_cooldown_ms <= 32'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_text("stop", 32'd1000);
    send_text("V", 32'd5);
    send_text("VC:", 32'd7);
    send_text("VCwake", 32'd1999);
    send_text("go_home", 32'd2000);
    send_byte(8'hFF, 1'b1, 32'hFFFF_FFFF);
    random_lines(80, 4);

    write_cooldown(32'd0);
    calm = 1'b1;
    random_lines(100, 4);
    calm = 1'b0;
    random_lines(50, 4);

    write_cooldown(32'hFFFF_FFFF);
    send_text("VC:Sleep", sb.last_accept - 32'd1);
    send_text("wake", sb.last_accept - 32'd1);
    send_text("stop", sb.last_accept);
    random_lines(80, 4);

    // The receiver holds off while short lines keep coming, so the block
    // fills up and stalls its input.
    write_cooldown($urandom_range(1, 5000));
    hold_req = 1'b1;
    random_lines(100, 1);
    random_lines(80, 4);

    write_cooldown($urandom());
    random_lines(100, 4);

    drain();
    if (sb.pending_cmds.size() != 0) sb.complain("missing command", sb.pending_cmds[0], 0);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ voice_keyword_matcher.f @@
rtl/vkm_pkg.sv
rtl/vkm_front.sv
rtl/vkm_cell.sv
rtl/voice_keyword_matcher.sv
rtl/vkm_checker.sv
tb/sv/tb_top.sv
